// ===== hw/rtl/wdw_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted draw package
// Shared widths, result and mode codes, the memory control group and the
// weight function of the weighted draw unit.
// ----------------------------------------------------------------------------
package wdw_pkg;

   localparam int ID_W        = 6;
   localparam int COUNT_W     = 6;
   localparam int ACTIVE_W    = 7;
   localparam int WEIGHT_W    = 64;
   localparam int RAND_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_LIMIT = 62;

   localparam logic MODE_RESTART = 1'b0;
   localparam logic MODE_DRAW    = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DRAWN     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RESTARTED = 2'd2;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctrl_type;

   // Identifier id weighs 2 << (active - id) while it is below the active count.
   function automatic logic [WEIGHT_W-1:0] weight_of(input logic [ID_W-1:0] id,
                                                     input logic [ACTIVE_W-1:0] active);
      logic [ACTIVE_W-1:0] amount;
      amount = 7'(active - {1'b0, id} + 7'd1);
      if ({1'b0, id} < active) begin
         weight_of = 64'd1 << amount;
      end else begin
         weight_of = '0;
      end
   endfunction

endpackage

// ===== hw/rtl/wdw_pool_mem.sv =====
// ----------------------------------------------------------------------------
// Pool memory
// Single-port-write, single-port-read memory holding the identifiers that
// are still available. Read data is registered.
// ----------------------------------------------------------------------------
module wdw_pool_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  wdw_pkg::mem_ctrl_type     mem_ctrl,
   input  logic [ADDR_W-1:0]         rd_addr,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [wdw_pkg::ID_W-1:0]  wr_data,
   output logic [wdw_pkg::ID_W-1:0]  rd_data
);
   import wdw_pkg::*;

   logic [ID_W-1:0] mem_array [DEPTH];
   logic [ID_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctrl.wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      if (mem_ctrl.rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/wdw_remainder.sv =====
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Reduces a 32-bit word modulo a 64-bit divisor by restoring division,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module wdw_remainder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wdw_pkg::RAND_W-1:0]    dividend,
   input  logic [wdw_pkg::WEIGHT_W-1:0]  divisor,
   output logic                          done,
   output logic [wdw_pkg::WEIGHT_W-1:0]  remainder
);
   import wdw_pkg::*;

   localparam int STEP_W = $clog2(RAND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [RAND_W-1:0]     bits_ff, bits_in;
   logic [WEIGHT_W-1:0]   rem_ff, rem_in;
   logic [WEIGHT_W:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      bits_in = bits_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, bits_ff[RAND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         bits_in = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = WEIGHT_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[WEIGHT_W-1:0];
         end
         bits_in = {bits_ff[RAND_W-2:0], 1'b0};
         step_in = STEP_W'(step_ff + 1'b1);
         if (step_ff == STEP_W'(RAND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      bits_ff <= bits_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/weighted_draw_without_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// Weighted draw without replacement unit
// Roulette-wheel selection of node identifiers from a pool held in memory.
// ----------------------------------------------------------------------------
// Items are handled one at a time, each giving one result item. A restart
// refills the pool memory one entry per cycle, up to the clipped node
// count. A draw runs the random word through the bit-serial remainder unit,
// then scans the pool at one memory read per cycle, then reads and writes
// back the last entry. A draw on an empty pool goes straight to the result.
// A result that waits for the receiver holds the unit in its done state.
module weighted_draw_without_replacement_unit #(
   parameter int POOL_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // random_value[31:0]
   input  logic        req_tuser,   // mode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // node_id[5:0]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data  // node_count[5:0]
);
   import wdw_pkg::*;

   localparam int ADDR_W = $clog2(POOL_DEPTH);
   localparam int CNT_W  = $clog2(POOL_DEPTH + 1);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_FILL    = 7'b0000010,
      ST_DIV     = 7'b0000100,
      ST_SCAN    = 7'b0001000,
      ST_MOVE_RD = 7'b0010000,
      ST_MOVE_WR = 7'b0100000,
      ST_DONE    = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     node_count_ff, node_count_in;
   logic [CNT_W-1:0]       active_ff, active_in;
   logic [CNT_W-1:0]       remaining_ff, remaining_in;
   logic [WEIGHT_W-1:0]    total_ff, total_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [CNT_W-1:0]       issue_ff, issue_in;
   logic [CNT_W-1:0]       check_ff, check_in;
   logic [WEIGHT_W-1:0]    accum_ff, accum_in;
   logic [WEIGHT_W-1:0]    target_ff, target_in;
   logic [ADDR_W-1:0]      slot_ff, slot_in;
   logic [ID_W-1:0]        res_id_ff, res_id_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                   rd_vld_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_data_ff, rsp_data_in;

   mem_ctrl_type           mem_ctrl;
   logic [ADDR_W-1:0]      mem_rd_addr;
   logic [ADDR_W-1:0]      mem_wr_addr;
   logic [ID_W-1:0]        mem_wr_data;
   logic [ID_W-1:0]        mem_rd_data;

   logic                   div_start;
   logic                   div_done;
   logic [WEIGHT_W-1:0]    div_rem;

   logic [ACTIVE_W-1:0]    count_clip;
   logic [CNT_W-1:0]       count_sel;
   logic [ACTIVE_W-1:0]    active_ext;
   logic [WEIGHT_W-1:0]    scan_sum;

   wdw_pool_mem #(
      .DEPTH  (POOL_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_pool_mem (
      .clock    (clock),
      .mem_ctrl (mem_ctrl),
      .rd_addr  (mem_rd_addr),
      .wr_addr  (mem_wr_addr),
      .wr_data  (mem_wr_data),
      .rd_data  (mem_rd_data)
   );

   wdw_remainder u_remainder (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_tdata),
      .divisor   (total_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff[5:0]};
   assign rsp_tuser  = rsp_data_ff[7:6];

   assign active_ext = ACTIVE_W'(active_ff);
   assign scan_sum   = accum_ff + weight_of(mem_rd_data, active_ext);

   always_comb begin
      count_clip = {1'b0, node_count_ff};
      if (count_clip > ACTIVE_W'(COUNT_LIMIT)) begin
         count_clip = ACTIVE_W'(COUNT_LIMIT);
      end
      if (count_clip > ACTIVE_W'(POOL_DEPTH)) begin
         count_clip = ACTIVE_W'(POOL_DEPTH);
      end
      count_sel = CNT_W'(count_clip);
   end

   always_comb begin
      state_in      = state_ff;
      node_count_in = node_count_ff;
      active_in     = active_ff;
      remaining_in  = remaining_ff;
      total_in      = total_ff;
      fill_in       = fill_ff;
      issue_in      = issue_ff;
      check_in      = check_ff;
      accum_in      = accum_ff;
      target_in     = target_ff;
      slot_in       = slot_ff;
      res_id_in     = res_id_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mem_ctrl      = '0;
      mem_rd_addr   = '0;
      mem_wr_addr   = '0;
      mem_wr_data   = '0;
      div_start     = 1'b0;

      if (csr_wr_en) begin
         node_count_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               res_id_in = '0;
               if (req_tuser == MODE_RESTART) begin
                  active_in     = count_sel;
                  remaining_in  = count_sel;
                  // The full pool weighs 2^(n+2) - 4.
                  total_in      = WEIGHT_W'(~({WEIGHT_W{1'b1}} << (count_clip + 7'd2)) - 64'd3);
                  fill_in       = '0;
                  res_status_in = STATUS_RESTARTED;
                  state_in      = (count_sel == '0) ? ST_DONE : ST_FILL;
               end else if (remaining_ff == '0 || total_ff == '0) begin
                  res_status_in = STATUS_EMPTY;
                  state_in      = ST_DONE;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_FILL: begin
            mem_ctrl.wr_en = 1'b1;
            mem_wr_addr    = fill_ff[ADDR_W-1:0];
            mem_wr_data    = ID_W'(fill_ff);
            fill_in        = CNT_W'(fill_ff + 1'b1);
            if (fill_ff == CNT_W'(active_ff - 1'b1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               target_in = div_rem;
               issue_in  = '0;
               check_in  = '0;
               accum_in  = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_ff < remaining_ff) begin
               mem_ctrl.rd_en = 1'b1;
               mem_rd_addr    = issue_ff[ADDR_W-1:0];
               issue_in       = CNT_W'(issue_ff + 1'b1);
            end
            if (rd_vld_ff) begin
               accum_in = scan_sum;
               check_in = CNT_W'(check_ff + 1'b1);
               if (target_ff < scan_sum || check_ff == CNT_W'(remaining_ff - 1'b1)) begin
                  slot_in   = check_ff[ADDR_W-1:0];
                  res_id_in = mem_rd_data;
                  state_in  = ST_MOVE_RD;
               end
            end
         end
         ST_MOVE_RD: begin
            mem_ctrl.rd_en = 1'b1;
            mem_rd_addr    = ADDR_W'(remaining_ff - 1'b1);
            state_in       = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            mem_ctrl.wr_en = 1'b1;
            mem_wr_addr    = slot_ff;
            mem_wr_data    = mem_rd_data;
            total_in       = total_ff - weight_of(res_id_ff, active_ext);
            remaining_in   = CNT_W'(remaining_ff - 1'b1);
            res_status_in  = STATUS_DRAWN;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_status_ff, res_id_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= 6'd8;
         active_ff     <= '0;
         remaining_ff  <= '0;
         total_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         active_ff     <= active_in;
         remaining_ff  <= remaining_in;
         total_ff      <= total_in;
         rd_vld_ff     <= mem_ctrl.rd_en;
         rsp_valid_ff  <= rsp_valid_in;
      end
      fill_ff       <= fill_in;
      issue_ff      <= issue_in;
      check_ff      <= check_in;
      accum_ff      <= accum_in;
      target_ff     <= target_in;
      slot_ff       <= slot_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

// ===== sim/tb_weighted_draw_without_replacement_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted draw without replacement unit testbench
// Sends restart and draw items through the request stream and compares each
// response with a local model of the pool, its count and its total weight.
// Starts with a directed sequence covering empty pools, clipped and zero node
// counts and extreme random words, then runs random restart-and-draw
// sequences under several node counts and three patterns of stream stalls.
// ----------------------------------------------------------------------------
module tb_weighted_draw_without_replacement_unit;
   import wdw_pkg::*;

   localparam int POOL_DEPTH  = 64;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_WAIT  = 200;

   typedef struct {
      logic        mode;
      logic [31:0] word;
   } draw_request_type;

   typedef struct {
      logic [ID_W-1:0]     node_id;
      logic [STATUS_W-1:0] status;
   } draw_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // random_value[31:0]
   logic        req_tuser = 1'b0; // mode[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // node_id[5:0]
   logic [1:0]  rsp_tuser;        // status[1:0]
   logic        csr_wr_en = 1'b0;
   logic [5:0]  csr_wr_data = '0; // node_count[5:0]

   draw_request_type draw_requests[$];
   draw_result_type  due_results[$];
   int            requests_queued = 0;
   int            results_seen = 0;
   int            error_count = 0;
   int            cycle_count = 0;
   int            send_idle = 0;
   int            recv_idle = 0;
   logic          req_fire = 1'b0;

   logic [ID_W-1:0]       pool_model[POOL_DEPTH];
   logic [ACTIVE_W-1:0]   pool_left = '0;
   logic [WEIGHT_W-1:0]   pool_weight = '0;
   logic [ACTIVE_W-1:0]   latched_count = '0;
   logic [COUNT_W-1:0]    count_reg = 6'd8;

   weighted_draw_without_replacement_unit #(
      .POOL_DEPTH(POOL_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < POOL_DEPTH; i++) begin
         pool_model[i] = ID_W'(i);
      end
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic logic [WEIGHT_W-1:0] node_weight(input logic [ID_W-1:0] id);
      if ({1'b0, id} >= latched_count || latched_count > COUNT_LIMIT) begin
         return '0;
      end
      return 64'd1 << (int'(latched_count) - int'(id) + 1);
   endfunction

   function automatic draw_result_type predict_draw(input logic mode, input logic [31:0] word);
      draw_result_type       res;
      int                    n;
      int                    slot;
      bit                    found;
      logic [WEIGHT_W-1:0]   target;
      logic [WEIGHT_W-1:0]   accum;
      logic [ID_W-1:0]       id;
      res.node_id = '0;
      if (mode == MODE_RESTART) begin
         n = int'(count_reg);
         if (n > COUNT_LIMIT) n = COUNT_LIMIT;
         if (n > POOL_DEPTH) n = POOL_DEPTH;
         for (int i = 0; i < POOL_DEPTH; i++) begin
            pool_model[i] = ID_W'(i);
         end
         latched_count = ACTIVE_W'(n);
         pool_left = ACTIVE_W'(n);
         pool_weight = '0;
         for (int i = 0; i < n; i++) begin
            pool_weight += node_weight(ID_W'(i));
         end
         res.status = STATUS_RESTARTED;
      end else if (pool_left == 0 || pool_weight == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         target = {32'd0, word} % pool_weight;
         accum = '0;
         slot = int'(pool_left) - 1;
         found = 1'b0;
         for (int j = 0; j < int'(pool_left) && j < POOL_DEPTH; j++) begin
            if (!found) begin
               accum += node_weight(pool_model[j]);
               if (target < accum) begin
                  slot = j;
                  found = 1'b1;
               end
            end
         end
         if (slot >= POOL_DEPTH) slot = POOL_DEPTH - 1;
         id = pool_model[slot];
         pool_weight -= node_weight(id);
         if (int'(pool_left) - 1 < POOL_DEPTH) begin
            pool_model[slot] = pool_model[int'(pool_left) - 1];
         end
         pool_left = pool_left - 1'b1;
         res.node_id = id;
         res.status = STATUS_DRAWN;
      end
      return res;
   endfunction

   always @(negedge clock) begin
      draw_request_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (draw_requests.size() > 0 && $urandom_range(99) >= send_idle) begin
            item = draw_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= item.mode;
            req_tdata <= item.word;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      draw_result_type due;
      req_fire <= req_tvalid && req_tready;
      if (!reset) begin
         if (csr_wr_en) begin
            count_reg = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            due_results.push_back(predict_draw(req_tuser, req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("response %h/%h arrived with nothing expected",
                                         rsp_tuser, rsp_tdata));
            end else begin
               due = due_results.pop_front();
               if (rsp_tuser !== due.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_tuser, due.status));
               end
               if (rsp_tdata[5:0] !== due.node_id) begin
                  report_mismatch($sformatf("node_id %0d, expected %0d",
                                            rsp_tdata[5:0], due.node_id));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic queue_request(input logic mode, input logic [31:0] word);
      draw_request_type item;
      item.mode = mode;
      item.word = word;
      draw_requests.push_back(item);
      requests_queued++;
   endtask

   task automatic wait_for_results();
      while (results_seen < requests_queued) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [5:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] random_word();
      case ($urandom_range(5))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'($urandom_range(1023));
         default: return $urandom;
      endcase
   endfunction

   task automatic run_node_count(input logic [5:0] value, input int budget);
      int n;
      int draws;
      int sent;
      write_node_count(value);
      n = (value > COUNT_LIMIT) ? COUNT_LIMIT : int'(value);
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 15) begin
            queue_request(1'($urandom_range(1)), $urandom);
            sent++;
         end else begin
            queue_request(MODE_RESTART, $urandom);
            if ($urandom_range(3) == 0) begin
               draws = n + $urandom_range(2);
            end else begin
               draws = $urandom_range(n);
            end
            for (int k = 0; k < draws; k++) begin
               queue_request(MODE_DRAW, random_word());
            end
            sent += draws + 1;
         end
      end
      wait_for_results();
   endtask

   task automatic run_phase();
      run_node_count(6'($urandom_range(1, 6)), 80);
      run_node_count(6'($urandom_range(2, 20)), 80);
      run_node_count(6'($urandom_range(63)), 80);
      run_node_count(6'd62, 80);
      run_node_count(6'd1, 80);
      run_node_count(6'($urandom_range(7, 40)), 80);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle = 13;
      recv_idle = 72;

      // Reset count of eight: empty pool first, then a full drain.
      queue_request(MODE_DRAW, 32'h0000_0000);
      queue_request(MODE_RESTART, 32'hFFFF_FFFF);
      queue_request(MODE_DRAW, 32'h0000_0000);
      queue_request(MODE_DRAW, 32'hFFFF_FFFF);
      queue_request(MODE_DRAW, 32'h5555_5555);
      queue_request(MODE_DRAW, 32'hAAAA_AAAA);
      for (int k = 0; k < 4; k++) begin
         queue_request(MODE_DRAW, $urandom);
      end
      queue_request(MODE_DRAW, 32'h1234_5678);
      queue_request(MODE_RESTART, 32'h0000_0000);
      queue_request(MODE_DRAW, 32'd1019);
      wait_for_results();

      write_node_count(6'd0);
      queue_request(MODE_RESTART, 32'h0000_0000);
      queue_request(MODE_DRAW, 32'hFFFF_FFFF);
      wait_for_results();

      write_node_count(6'd63);
      queue_request(MODE_RESTART, 32'h0000_0000);
      queue_request(MODE_DRAW, 32'hFFFF_FFFF);
      queue_request(MODE_DRAW, 32'h0000_0000);
      wait_for_results();

      write_node_count(6'd1);
      queue_request(MODE_RESTART, 32'h0000_0000);
      queue_request(MODE_DRAW, 32'hFFFF_FFFF);
      queue_request(MODE_DRAW, 32'h0000_0000);
      wait_for_results();

      run_phase();

      send_idle = 72;
      recv_idle = 13;
      run_phase();

      send_idle = 0;
      recv_idle = 0;
      run_phase();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (due_results.size() != 0) begin
         report_mismatch($sformatf("%0d expected responses never arrived",
                                   due_results.size()));
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
